### hdl/rcsa_pkg.sv
// Shared constants, phase codes and the result type for the stick scaling and arming block.
`timescale 1ns / 1ps

package rcsa_pkg;

	// Raw receiver channel width
	localparam int CHANNEL_BITS = 11;
	// Width of the scaled commands, offsets and switch outputs
	localparam int CMD_BITS     = 11;
	// Signed working width for the scaled value in eighths
	localparam int SCALE_BITS   = CHANNEL_BITS + 8;
	// Width that holds both a raw switch channel and an 11-bit register
	localparam int MATCH_BITS   = (CHANNEL_BITS > CMD_BITS) ? CHANNEL_BITS : CMD_BITS;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 12;
	localparam int AUTOLOCK_BITS  = 12;
	localparam int HOLD_BITS      = 8;
	localparam int LOW_CNT_BITS   = 13;
	localparam int PHASE_BITS     = 3;

	// Configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ROLL_OFFSET     = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_PITCH_OFFSET    = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_THROTTLE_OFFSET = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_YAW_OFFSET      = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ARM_SWITCH      = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_AUTOLOCK        = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLD_LIMIT      = 3'd6;

	// Register reset values
	localparam logic [CMD_BITS-1:0]      RST_ROLL_OFFSET     = 11'd216;
	localparam logic [CMD_BITS-1:0]      RST_PITCH_OFFSET    = 11'd187;
	localparam logic [CMD_BITS-1:0]      RST_THROTTLE_OFFSET = 11'd184;
	localparam logic [CMD_BITS-1:0]      RST_YAW_OFFSET      = 11'd216;
	localparam logic [CMD_BITS-1:0]      RST_ARM_SWITCH      = 11'd1800;
	localparam logic [AUTOLOCK_BITS-1:0] RST_AUTOLOCK        = 12'd3000;
	localparam logic [HOLD_BITS-1:0]     RST_HOLD_LIMIT      = 8'd5;

	// Command range and stick thresholds
	localparam logic [CMD_BITS-1:0] CMD_MIN       = 11'd1000;
	localparam logic [CMD_BITS-1:0] CMD_MAX       = 11'd2000;
	localparam logic [CMD_BITS-1:0] THR_LOCK      = 11'd1050;
	localparam logic [CMD_BITS-1:0] YAW_LOCK      = 11'd1200;
	localparam logic [CMD_BITS-1:0] THR_START_LOW = 11'd1150;
	localparam logic [CMD_BITS-1:0] THR_HIGH      = 11'd1600;
	localparam logic [CMD_BITS-1:0] THR_ARM_LOW   = 11'd1100;
	localparam logic [CMD_BITS-1:0] THR_IDLE      = 11'd1020;

	// Scale bases in eighths
	localparam int BASE_NORMAL   = 8000;
	localparam int BASE_INVERTED = 16000;

	// Arming phases
	localparam logic [PHASE_BITS-1:0] PH_WAIT_LOW  = 3'd0;
	localparam logic [PHASE_BITS-1:0] PH_WAIT_HIGH = 3'd1;
	localparam logic [PHASE_BITS-1:0] PH_WAIT_DROP = 3'd2;
	localparam logic [PHASE_BITS-1:0] PH_ARM       = 3'd3;
	localparam logic [PHASE_BITS-1:0] PH_ARMED     = 3'd4;
	localparam logic [PHASE_BITS-1:0] PH_LOCK      = 3'd5;

	typedef struct packed {
		logic                  armed;
		logic                  led_solid;
		logic                  started;
		logic                  imu_reset;
		logic [PHASE_BITS-1:0] arm_phase;
	} arm_result_t;

endpackage

### hdl/rc_stick_scaling_and_arming.sv
// Top level of the receiver stick scaling and arming block.
// Path: an accepted item is held in the input register, and its result moves into the
// output register when the output is not stalled, and out_valid then rises
// (input register, then output register).
// Throughput: one item per cycle while the output is not stalled; the input register
// refills in the same cycle the output is taken, and in_stall follows the output stall.
// Reset: arst_n clears the pipeline valids, the arming phase and counters, the start
// flag, and loads the configuration registers with their default values.
`timescale 1ns / 1ps

module rc_stick_scaling_and_arming
	import rcsa_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,

	// configuration write channel
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,

	// input item channel: one receiver frame
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [CHANNEL_BITS-1:0]   raw_roll,
	input  logic [CHANNEL_BITS-1:0]   raw_pitch,
	input  logic [CHANNEL_BITS-1:0]   raw_throttle,
	input  logic [CHANNEL_BITS-1:0]   raw_yaw,
	input  logic [CHANNEL_BITS-1:0]   raw_switch_left,
	input  logic [CHANNEL_BITS-1:0]   raw_switch_right,

	// result item channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [CMD_BITS-1:0]       roll_cmd,
	output logic [CMD_BITS-1:0]       pitch_cmd,
	output logic [CMD_BITS-1:0]       throttle_cmd,
	output logic [CMD_BITS-1:0]       yaw_cmd,
	output logic [CMD_BITS-1:0]       aux_one,
	output logic [CMD_BITS-1:0]       aux_two,
	output logic                      armed,
	output logic                      led_solid,
	output logic                      started,
	output logic                      imu_reset,
	output logic [PHASE_BITS-1:0]     arm_phase
);

	// configuration registers
	logic [CMD_BITS-1:0]      roll_offset_q;
	logic [CMD_BITS-1:0]      pitch_offset_q;
	logic [CMD_BITS-1:0]      throttle_offset_q;
	logic [CMD_BITS-1:0]      yaw_offset_q;
	logic [CMD_BITS-1:0]      arm_switch_q;
	logic [AUTOLOCK_BITS-1:0] autolock_q;
	logic [HOLD_BITS-1:0]     hold_limit_q;

	// input register stage
	logic                    valid_s1;
	logic [CHANNEL_BITS-1:0] roll_s1;
	logic [CHANNEL_BITS-1:0] pitch_s1;
	logic [CHANNEL_BITS-1:0] throttle_s1;
	logic [CHANNEL_BITS-1:0] yaw_s1;
	logic [CHANNEL_BITS-1:0] sw_left_s1;
	logic [CHANNEL_BITS-1:0] sw_right_s1;

	// output register stage
	logic                  out_valid_q;
	logic [CMD_BITS-1:0]   roll_q;
	logic [CMD_BITS-1:0]   pitch_q;
	logic [CMD_BITS-1:0]   throttle_q;
	logic [CMD_BITS-1:0]   yaw_q;
	logic [CMD_BITS-1:0]   aux_one_q;
	logic [CMD_BITS-1:0]   aux_two_q;
	arm_result_t           arm_q;

	// stage logic
	logic                  advance;
	logic                  step;
	logic                  in_take;
	logic [CMD_BITS-1:0]   roll_val;
	logic [CMD_BITS-1:0]   pitch_val;
	logic [CMD_BITS-1:0]   throttle_val;
	logic [CMD_BITS-1:0]   yaw_val;
	logic                  switch_armed;
	arm_result_t           arm_val;

	// Configuration is always accepted; the sender must write only while no item is in flight (unenforced here).
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_offset_q     <= RST_ROLL_OFFSET;
			pitch_offset_q    <= RST_PITCH_OFFSET;
			throttle_offset_q <= RST_THROTTLE_OFFSET;
			yaw_offset_q      <= RST_YAW_OFFSET;
			arm_switch_q      <= RST_ARM_SWITCH;
			autolock_q        <= RST_AUTOLOCK;
			hold_limit_q      <= RST_HOLD_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ROLL_OFFSET:     roll_offset_q     <= cfg_data[CMD_BITS-1:0];
				CFG_PITCH_OFFSET:    pitch_offset_q    <= cfg_data[CMD_BITS-1:0];
				CFG_THROTTLE_OFFSET: throttle_offset_q <= cfg_data[CMD_BITS-1:0];
				CFG_YAW_OFFSET:      yaw_offset_q      <= cfg_data[CMD_BITS-1:0];
				CFG_ARM_SWITCH:      arm_switch_q      <= cfg_data[CMD_BITS-1:0];
				CFG_AUTOLOCK:        autolock_q        <= cfg_data[AUTOLOCK_BITS-1:0];
				CFG_HOLD_LIMIT:      hold_limit_q      <= cfg_data[HOLD_BITS-1:0];
				default: begin
					// drop writes to indexes past the register list
				end
			endcase
		end
	end

	// Advance the output register when it is empty or being taken this cycle.
	assign advance  = !out_valid_q || !out_stall;
	// Step the arming sequencer exactly once per item, as it moves to the output.
	assign step     = valid_s1 && advance;
	// Hold off the sender only while the input register is full and cannot move on.
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			roll_s1     <= raw_roll;
			pitch_s1    <= raw_pitch;
			throttle_s1 <= raw_throttle;
			yaw_s1      <= raw_yaw;
			sw_left_s1  <= raw_switch_left;
			sw_right_s1 <= raw_switch_right;
		end
	end

	// Scale the four sticks; pitch and yaw are inverted.
	rcsa_stick_scale u_roll (
		.raw    (roll_s1),
		.offset (roll_offset_q),
		.invert (1'b0),
		.cmd    (roll_val)
	);

	rcsa_stick_scale u_pitch (
		.raw    (pitch_s1),
		.offset (pitch_offset_q),
		.invert (1'b1),
		.cmd    (pitch_val)
	);

	rcsa_stick_scale u_throttle (
		.raw    (throttle_s1),
		.offset (throttle_offset_q),
		.invert (1'b0),
		.cmd    (throttle_val)
	);

	rcsa_stick_scale u_yaw (
		.raw    (yaw_s1),
		.offset (yaw_offset_q),
		.invert (1'b1),
		.cmd    (yaw_val)
	);

	// The arm switch must match the configured value exactly.
	assign switch_armed = (MATCH_BITS'(sw_left_s1) == MATCH_BITS'(arm_switch_q));

	// Run the arming sequence on the freshly scaled throttle and yaw.
	rcsa_arm_fsm u_arm (
		.clk                 (clk),
		.arst_n              (arst_n),
		.step                (step),
		.throttle_cmd        (throttle_val),
		.yaw_cmd             (yaw_val),
		.switch_armed        (switch_armed),
		.autolock_limit      (autolock_q),
		.throttle_hold_limit (hold_limit_q),
		.result              (arm_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			roll_q     <= roll_val;
			pitch_q    <= pitch_val;
			throttle_q <= throttle_val;
			yaw_q      <= yaw_val;
			// Switch channels pass through unchanged.
			aux_one_q  <= CMD_BITS'(sw_right_s1);
			aux_two_q  <= CMD_BITS'(sw_left_s1);
			arm_q      <= arm_val;
		end
	end

	assign out_valid    = out_valid_q;
	assign roll_cmd     = roll_q;
	assign pitch_cmd    = pitch_q;
	assign throttle_cmd = throttle_q;
	assign yaw_cmd      = yaw_q;
	assign aux_one      = aux_one_q;
	assign aux_two      = aux_two_q;
	assign armed        = arm_q.armed;
	assign led_solid    = arm_q.led_solid;
	assign started      = arm_q.started;
	assign imu_reset    = arm_q.imu_reset;
	assign arm_phase    = arm_q.arm_phase;

endmodule

### hdl/rcsa_stick_scale.sv
// Stick scaler: (raw - offset) * 5/8 around 1000 or inverted around 2000, clamped.
`timescale 1ns / 1ps

module rcsa_stick_scale
	import rcsa_pkg::*;
(
	input  logic [CHANNEL_BITS-1:0] raw,
	input  logic [CMD_BITS-1:0]     offset,
	input  logic                    invert,
	output logic [CMD_BITS-1:0]     cmd
);

	logic signed [SCALE_BITS-1:0] diff;
	logic signed [SCALE_BITS-1:0] five_diff;
	logic signed [SCALE_BITS-1:0] eighths;
	logic signed [SCALE_BITS-1:0] whole;

	always_comb begin
		diff      = $signed(SCALE_BITS'(raw)) - $signed(SCALE_BITS'(offset));
		five_diff = (diff <<< 2) + diff;
		if (invert) begin
			eighths = $signed(SCALE_BITS'(BASE_INVERTED)) - five_diff;
		end else begin
			eighths = $signed(SCALE_BITS'(BASE_NORMAL)) + five_diff;
		end
		// eighths is non-negative past the first test, so the shift truncates
		whole = eighths >>> 3;
		if (eighths < $signed(SCALE_BITS'(BASE_NORMAL))) begin
			cmd = CMD_MIN;
		end else if (whole > $signed(SCALE_BITS'(CMD_MAX))) begin
			cmd = CMD_MAX;
		end else begin
			cmd = whole[CMD_BITS-1:0];
		end
	end

endmodule

### hdl/rcsa_arm_fsm.sv
// Arming sequencer: phase, throttle counters and sticky start flag, one step per item.
`timescale 1ns / 1ps

module rcsa_arm_fsm
	import rcsa_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic [CMD_BITS-1:0]      throttle_cmd,
	input  logic [CMD_BITS-1:0]      yaw_cmd,
	input  logic                     switch_armed,
	input  logic [AUTOLOCK_BITS-1:0] autolock_limit,
	input  logic [HOLD_BITS-1:0]     throttle_hold_limit,
	output arm_result_t              result
);

	logic [PHASE_BITS-1:0]   phase_q;
	logic [LOW_CNT_BITS-1:0] low_cnt_q;
	logic [HOLD_BITS-1:0]    high_cnt_q;
	logic                    start_q;

	logic [PHASE_BITS-1:0]   phase_cur;
	logic [PHASE_BITS-1:0]   phase_nxt;
	logic [LOW_CNT_BITS-1:0] low_cnt_nxt;
	logic [HOLD_BITS-1:0]    high_cnt_nxt;
	logic [HOLD_BITS-1:0]    high_cnt_inc;
	logic                    start_nxt;
	logic                    armed;
	logic                    led_solid;
	logic                    imu_pulse;

	always_comb begin
		phase_cur    = phase_q;
		phase_nxt    = phase_q;
		low_cnt_nxt  = low_cnt_q;
		high_cnt_nxt = high_cnt_q;
		high_cnt_inc = high_cnt_q + 1'b1;
		start_nxt    = start_q | switch_armed;
		armed        = switch_armed;
		led_solid    = switch_armed;
		imu_pulse    = 1'b0;

		// low throttle with low yaw forces a lock in this same frame
		if ((throttle_cmd < THR_LOCK) && (yaw_cmd < YAW_LOCK)) begin
			phase_cur = PH_LOCK;
		end
		phase_nxt = phase_cur;

		unique case (phase_cur)
			PH_WAIT_LOW: begin
				if (throttle_cmd < THR_START_LOW) begin
					phase_nxt = PH_WAIT_HIGH;
				end
			end
			PH_WAIT_HIGH: begin
				if (throttle_cmd > THR_HIGH) begin
					if (high_cnt_inc > throttle_hold_limit) begin
						high_cnt_nxt = '0;
						phase_nxt    = PH_WAIT_DROP;
					end else begin
						high_cnt_nxt = high_cnt_inc;
					end
				end
			end
			PH_WAIT_DROP: begin
				if (throttle_cmd < THR_ARM_LOW) begin
					phase_nxt = PH_ARM;
				end
			end
			PH_ARM: begin
				armed     = 1'b1;
				led_solid = 1'b1;
				imu_pulse = 1'b1;
				start_nxt = 1'b1;
				phase_nxt = PH_ARMED;
			end
			PH_ARMED: begin
				if (throttle_cmd < THR_IDLE) begin
					low_cnt_nxt = low_cnt_q + 1'b1;
					if (low_cnt_q > LOW_CNT_BITS'(autolock_limit)) begin
						phase_nxt = PH_LOCK;
					end
				end else if (!switch_armed) begin
					phase_nxt = PH_LOCK;
				end else begin
					low_cnt_nxt = '0;
				end
			end
			default: begin
				// lock and the unused codes
				led_solid   = 1'b0;
				armed       = 1'b0;
				low_cnt_nxt = '0;
				phase_nxt   = PH_WAIT_LOW;
			end
		endcase

		result.armed     = armed;
		result.led_solid = led_solid;
		result.started   = start_nxt;
		result.imu_reset = imu_pulse;
		result.arm_phase = phase_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_WAIT_LOW;
			low_cnt_q  <= '0;
			high_cnt_q <= '0;
			start_q    <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_nxt;
			low_cnt_q  <= low_cnt_nxt;
			high_cnt_q <= high_cnt_nxt;
			start_q    <= start_nxt;
		end
	end

endmodule
